// ===== hdl/itr_pkg.sv =====
// Shared constants, types and the arctangent table for the IMU tilt and rate integrator.
// No dependencies; used by itr_cordic, itr_gyro and the top level.
`default_nettype none

package itr_pkg;

  // CORDIC length and datapath widths
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int TAB_IDX_W    = 5;           // table holds 17 entries (0 to 16)
  localparam int AXIS_W       = 16;
  localparam int XY_W         = 28;          // inputs * 256 plus CORDIC gain
  localparam int ANG_W        = 20;          // angle accumulator, radians Q.16
  localparam int TILT_W       = 16;
  localparam int SUM_W        = 32;
  localparam int GAIN_W       = 12;
  localparam int PROD_W       = AXIS_W + GAIN_W + 1;
  localparam int PAIR_W       = 2;
  localparam int NUM_PAIRS    = 3;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(10);

  localparam logic signed [ANG_W-1:0] PI_Q16     = ANG_W'(205887);
  localparam logic signed [ANG_W-1:0] NEG_PI_Q16 = -ANG_W'(205887);
  localparam logic signed [ANG_W-1:0] TILT_MAX   = ANG_W'(25736);
  localparam logic signed [ANG_W-1:0] TILT_MIN   = -ANG_W'(25736);
  localparam logic signed [ANG_W-1:0] RND_BIAS   = ANG_W'(4);

  localparam logic [PAIR_W-1:0] LAST_PAIR = PAIR_W'(NUM_PAIRS - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  typedef struct packed {
    logic              load;
    logic              step;
    logic [STEP_W-1:0] idx;
  } cordic_ctrl_t;

  typedef struct packed {
    logic              en;
    logic [PAIR_W-1:0] idx;
  } gyro_ctrl_t;

  // atan(2^-i) in Q.16, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] i);
    logic signed [ANG_W-1:0] v;
    case (i)
      5'd0:    v = ANG_W'(51472);
      5'd1:    v = ANG_W'(30386);
      5'd2:    v = ANG_W'(16055);
      5'd3:    v = ANG_W'(8150);
      5'd4:    v = ANG_W'(4091);
      5'd5:    v = ANG_W'(2047);
      5'd6:    v = ANG_W'(1024);
      5'd7:    v = ANG_W'(512);
      5'd8:    v = ANG_W'(256);
      5'd9:    v = ANG_W'(128);
      5'd10:   v = ANG_W'(64);
      5'd11:   v = ANG_W'(32);
      5'd12:   v = ANG_W'(16);
      5'd13:   v = ANG_W'(8);
      5'd14:   v = ANG_W'(4);
      5'd15:   v = ANG_W'(2);
      5'd16:   v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/itr_cordic.sv =====
// Shared vectoring CORDIC: one micro-rotation per step, Q3.13 result with clamp.
// Depends on itr_pkg.
`default_nettype none

module itr_cordic (
  input  wire                                clk,
  input  wire                                rst,
  input  wire itr_pkg::cordic_ctrl_t         ctrl,
  input  wire logic signed [itr_pkg::AXIS_W-1:0] y_in,
  input  wire logic signed [itr_pkg::AXIS_W-1:0] x_in,
  output logic signed [itr_pkg::TILT_W-1:0]  tilt
);

  logic signed [itr_pkg::XY_W-1:0]  x;
  logic signed [itr_pkg::XY_W-1:0]  y;
  logic signed [itr_pkg::ANG_W-1:0] ang;
  logic                             zero;

  logic signed [itr_pkg::XY_W-1:0]  xs;
  logic signed [itr_pkg::XY_W-1:0]  ys;
  logic signed [itr_pkg::XY_W-1:0]  dx;
  logic signed [itr_pkg::XY_W-1:0]  dy;
  logic signed [itr_pkg::ANG_W-1:0] da;
  logic signed [itr_pkg::ANG_W-1:0] rnd;

  assign xs = itr_pkg::XY_W'(x_in) <<< 8;
  assign ys = itr_pkg::XY_W'(y_in) <<< 8;
  assign dx = y >>> ctrl.idx;
  assign dy = x >>> ctrl.idx;
  assign da = itr_pkg::atan_entry(itr_pkg::TAB_IDX_W'(ctrl.idx));

  always_ff @(posedge clk) begin
    if (rst) begin
      zero <= 1'b1;
    end else if (ctrl.load) begin
      zero <= (x_in == '0) && (y_in == '0);
    end
    if (ctrl.load) begin
      // left half-plane: rotate by pi first
      if (x_in[itr_pkg::AXIS_W-1]) begin
        x   <= -xs;
        y   <= -ys;
        ang <= !y_in[itr_pkg::AXIS_W-1] ? itr_pkg::PI_Q16 : itr_pkg::NEG_PI_Q16;
      end else begin
        x   <= xs;
        y   <= ys;
        ang <= '0;
      end
    end else if (ctrl.step) begin
      if (!y[itr_pkg::XY_W-1]) begin
        x   <= x + dx;
        y   <= y - dy;
        ang <= ang + da;
      end else begin
        x   <= x - dx;
        y   <= y + dy;
        ang <= ang - da;
      end
    end
  end

  // round Q.16 to Q3.13, floor after bias
  assign rnd = (ang + itr_pkg::RND_BIAS) >>> 3;

  always_comb begin
    if (zero) begin
      tilt = '0;
    end else if (rnd > itr_pkg::TILT_MAX) begin
      tilt = itr_pkg::TILT_W'(itr_pkg::TILT_MAX);
    end else if (rnd < itr_pkg::TILT_MIN) begin
      tilt = itr_pkg::TILT_W'(itr_pkg::TILT_MIN);
    end else begin
      tilt = itr_pkg::TILT_W'(rnd);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/itr_gyro.sv =====
// Gyro angle sums: registered rate*gain product, then saturating 32-bit add.
// Depends on itr_pkg.
`default_nettype none

module itr_gyro (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire itr_pkg::gyro_ctrl_t                ctrl,
  input  wire logic signed [itr_pkg::AXIS_W-1:0]  rate,
  input  wire logic [itr_pkg::GAIN_W-1:0]         gain,
  output logic [itr_pkg::NUM_PAIRS-1:0][itr_pkg::SUM_W-1:0] sums
);

  logic signed [itr_pkg::PROD_W-1:0] prod;
  logic                              pend;
  logic [itr_pkg::PAIR_W-1:0]        pend_idx;
  logic signed [itr_pkg::SUM_W:0]    wide;
  logic [itr_pkg::SUM_W-1:0]         sat;

  assign wide = (itr_pkg::SUM_W + 1)'(signed'(sums[pend_idx])) + (itr_pkg::SUM_W + 1)'(prod);

  always_comb begin
    if (wide[itr_pkg::SUM_W] != wide[itr_pkg::SUM_W-1]) begin
      sat = wide[itr_pkg::SUM_W] ? {1'b1, {(itr_pkg::SUM_W-1){1'b0}}}
                                 : {1'b0, {(itr_pkg::SUM_W-1){1'b1}}};
    end else begin
      sat = wide[itr_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sums <= '0;
      pend <= 1'b0;
    end else begin
      pend <= ctrl.en;
      if (pend) begin
        sums[pend_idx] <= sat;
      end
    end
    if (ctrl.en) begin
      prod     <= itr_pkg::PROD_W'(rate) * itr_pkg::PROD_W'($signed({1'b0, gain}));
      pend_idx <= ctrl.idx;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/imu_tilt_and_rate_integrator_unit.sv =====
// Top level of the IMU tilt and rate integrator: beat registers, sequencer, gain register.
// Depends on itr_pkg, itr_cordic and itr_gyro.
//
// Use: one input beat on s_* carries one IMU sample (three accel axes, three gyro
// rates). One output beat on m_* carries three tilt angles (Q3.13 radians, from a
// shared CORDIC) and the three gyro angle sums after this sample's update.
// An input beat is taken only while the sequencer is idle; s_tready then drops
// for the whole computation. The CORDIC handles the three axis pairs one after
// the other: per pair a load, CORDIC_STEPS micro-rotations and a store of the
// angle. One gyro sum is updated alongside each pair through the shared
// multiplier. A new sample is taken only after the last one's result has left
// the sequencer, so samples never overlap; the single CORDIC sets the pace.
// The result sits in an output register; a new sample is accepted while it
// waits. If the receiver still stalls when the next result is ready, the
// sequencer holds that result in its angle registers until m_tready frees the
// output register.
// Reset (rst, synchronous) clears the sums, sets rate_gain to 10, empties the
// output. cfg_wr_en writes rate_gain; write only while idle.
`default_nettype none

module imu_tilt_and_rate_integrator_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z (16 bit each)
  input  wire  [95:0] s_tdata,
  output logic        m_tvalid,
  input  wire         m_tready,
  // tilt_about_z, tilt_about_x, tilt_about_y (16 bit each),
  // turned_about_z, turned_about_x, turned_about_y (32 bit each)
  output logic [143:0] m_tdata,
  input  wire         cfg_wr_en,
  input  wire  [11:0] cfg_wr_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_STEP,
    S_SAVE,
    S_FINISH
  } state_t;

  state_t state;

  logic [itr_pkg::PAIR_W-1:0] pair;
  logic [itr_pkg::STEP_W-1:0] step_cnt;
  logic [itr_pkg::GAIN_W-1:0] rate_gain;

  // latched sample
  logic signed [itr_pkg::AXIS_W-1:0] accel_x, accel_y, accel_z;
  logic signed [itr_pkg::AXIS_W-1:0] rate_x, rate_y, rate_z;

  logic [itr_pkg::NUM_PAIRS-1:0][itr_pkg::TILT_W-1:0] tilts;

  itr_pkg::cordic_ctrl_t             cordic_ctrl;
  itr_pkg::gyro_ctrl_t               gyro_ctrl;
  logic signed [itr_pkg::AXIS_W-1:0] op_y, op_x, rate_sel;
  logic signed [itr_pkg::TILT_W-1:0] tilt;
  logic [itr_pkg::NUM_PAIRS-1:0][itr_pkg::SUM_W-1:0] sums;
  logic                              out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // operand pairs: (ax,ay) about z, (az,ay) about x, (ax,az) about y
  always_comb begin
    case (pair)
      2'd0: begin
        op_y     = accel_x;
        op_x     = accel_y;
        rate_sel = rate_z;
      end
      2'd1: begin
        op_y     = accel_z;
        op_x     = accel_y;
        rate_sel = rate_x;
      end
      default: begin
        op_y     = accel_x;
        op_x     = accel_z;
        rate_sel = rate_y;
      end
    endcase
  end

  assign cordic_ctrl.load = (state == S_LOAD);
  assign cordic_ctrl.step = (state == S_STEP);
  assign cordic_ctrl.idx  = step_cnt;
  assign gyro_ctrl.en     = (state == S_LOAD);
  assign gyro_ctrl.idx    = pair;

  itr_cordic u_cordic (
    .clk  (clk),
    .rst  (rst),
    .ctrl (cordic_ctrl),
    .y_in (op_y),
    .x_in (op_x),
    .tilt (tilt)
  );

  itr_gyro u_gyro (
    .clk  (clk),
    .rst  (rst),
    .ctrl (gyro_ctrl),
    .rate (rate_sel),
    .gain (rate_gain),
    .sums (sums)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_gain <= itr_pkg::GAIN_RESET;
    end else if (cfg_wr_en) begin
      rate_gain <= cfg_wr_data;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pair     <= '0;
      step_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // new result replaces or follows the one being taken
      if (state == S_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            pair  <= '0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          step_cnt <= '0;
          state    <= S_STEP;
        end
        S_STEP: begin
          if (step_cnt == itr_pkg::LAST_STEP) begin
            state <= S_SAVE;
          end else begin
            step_cnt <= step_cnt + itr_pkg::STEP_W'(1);
          end
        end
        S_SAVE: begin
          if (pair == itr_pkg::LAST_PAIR) begin
            state <= S_FINISH;
          end else begin
            pair  <= pair + itr_pkg::PAIR_W'(1);
            state <= S_LOAD;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    // payload registers
    if (s_tvalid && s_tready) begin
      accel_x <= s_tdata[15:0];
      accel_y <= s_tdata[31:16];
      accel_z <= s_tdata[47:32];
      rate_x  <= s_tdata[63:48];
      rate_y  <= s_tdata[79:64];
      rate_z  <= s_tdata[95:80];
    end
    if (state == S_SAVE) begin
      tilts[pair] <= tilt;
    end
    if (state == S_FINISH && out_free) begin
      m_tdata <= {sums[2], sums[1], sums[0], tilts[2], tilts[1], tilts[0]};
    end
  end

`ifndef NO_ASSERTIONS
  // taking a sample starts the sequencer, so the next cycle cannot accept
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted twice in a row");

  // pair counter never leaves the three axis pairs
  a_pair_range: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> pair <= itr_pkg::LAST_PAIR)
    else $error("pair counter out of range");

  // a result appears only out of the finish state
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_FINISH))
    else $error("output loaded outside finish");

  // the finish state never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH && m_tvalid && !m_tready |=> state == S_FINISH)
    else $error("finish left while output stalled");

  // a pair is stored only after the full step count
  a_save_after_steps: assert property (@(posedge clk) disable iff (rst)
    state == S_SAVE |-> $past(state == S_STEP) && step_cnt == itr_pkg::LAST_STEP)
    else $error("angle stored before last micro-rotation");
`endif

endmodule

`default_nettype wire

// ===== bench/imu_tilt_and_rate_integrator_unit_tb.sv =====
// Self-checking bench for imu_tilt_and_rate_integrator_unit: tilt angles and gyro sums.
// Depends on itr_pkg (widths, CORDIC length) and the top-level RTL; needs no files.
`timescale 1ns / 100ps

module imu_tilt_and_rate_integrator_unit_tb;

  localparam int AW = itr_pkg::AXIS_W;
  localparam int TW = itr_pkg::TILT_W;
  localparam int SW = itr_pkg::SUM_W;
  localparam int GW = itr_pkg::GAIN_W;

  // arctangent constants, radians Q.16, and the clamp of the tilt output
  localparam longint HALF_TURN_Q16 = 205887;
  localparam longint TILT_CLAMP    = 25736;
  localparam int     ATAN_TAB_LEN  = 24;
  localparam longint SUM_TOP       = 64'sd2147483647;
  localparam longint SUM_BOTTOM    = -64'sd2147483648;

  typedef enum logic [1:0] {
    FEED_SAMPLE,
    FEED_GAIN,
    FEED_DRAIN
  } feed_kind_t;

  // what the stimulus aims at for one random phase
  typedef enum logic [2:0] {
    MIX_FULL,
    MIX_TINY,
    MIX_EDGE,
    MIX_RAMP_UP,
    MIX_RAMP_DOWN
  } sample_mix_t;

  typedef struct packed {
    feed_kind_t               kind;
    logic                     hurry;  // present with no idle cycles
    logic [GW-1:0]            gain;
    logic signed [AW-1:0]     ax;
    logic signed [AW-1:0]     ay;
    logic signed [AW-1:0]     az;
    logic signed [AW-1:0]     rx;
    logic signed [AW-1:0]     ry;
    logic signed [AW-1:0]     rz;
  } feed_entry_t;

  // last member sits in the lowest bits of m_tdata
  typedef struct packed {
    logic signed [SW-1:0] turned_y;
    logic signed [SW-1:0] turned_x;
    logic signed [SW-1:0] turned_z;
    logic signed [TW-1:0] tilt_y;
    logic signed [TW-1:0] tilt_x;
    logic signed [TW-1:0] tilt_z;
  } imu_result_t;

  // DUT ports
  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;
  logic         cfg_wr_en = 1'b0;
  logic [11:0]  cfg_wr_data = '0;

  // bench state
  feed_entry_t  sample_feed[$];
  imu_result_t  pending_results[$];
  feed_entry_t  in_flight;
  feed_entry_t  head;
  imu_result_t  want;
  imu_result_t  got;
  longint       turned_sums[3];
  longint       gain_model;
  int           send_gap;
  int           take_stall;
  int           stall_pick;
  int           beats_seen;
  int           fault_count;

  imu_tilt_and_rate_integrator_unit uut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // atan(2^-k) in Q.16, rounded to nearest; zero past k = 16
  function automatic longint atan_step(input int k);
    if (k > 16) return 0;
    return longint'($rtoi($floor($atan(2.0 ** (-k)) * 65536.0 + 0.5)));
  endfunction

  // Four-quadrant arctangent of num/den by vectoring CORDIC, Q3.13 out.
  function automatic logic signed [TW-1:0] cordic_angle(input longint num,
                                                        input longint den);
    longint xv;
    longint yv;
    longint ang;
    longint dx;
    longint dy;
    longint r;
    if (num == 0 && den == 0) return '0;
    xv  = den * 256;
    yv  = num * 256;
    ang = 0;
    // left half plane: start at +/-pi and rotate the vector by pi
    if (xv < 0) begin
      ang = (yv >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
      xv  = -xv;
      yv  = -yv;
    end
    for (int k = 0; k < itr_pkg::CORDIC_STEPS && k < ATAN_TAB_LEN; k++) begin
      dx = yv >>> k;
      dy = xv >>> k;
      if (yv >= 0) begin
        xv  = xv + dx;
        yv  = yv - dy;
        ang = ang + atan_step(k);
      end else begin
        xv  = xv - dx;
        yv  = yv + dy;
        ang = ang - atan_step(k);
      end
    end
    r = (ang + 4) >>> 3;
    if (r > TILT_CLAMP) r = TILT_CLAMP;
    if (r < -TILT_CLAMP) r = -TILT_CLAMP;
    return TW'(r);
  endfunction

  function automatic longint add_turn(input longint sum, input longint rate);
    longint s;
    s = sum + rate * gain_model;
    if (s > SUM_TOP) s = SUM_TOP;
    if (s < SUM_BOTTOM) s = SUM_BOTTOM;
    return s;
  endfunction

  // updates the running sums, so call exactly once per accepted sample
  function automatic imu_result_t predict_sample(input feed_entry_t smp);
    imu_result_t res;
    turned_sums[0] = add_turn(turned_sums[0], longint'(smp.rz));
    turned_sums[1] = add_turn(turned_sums[1], longint'(smp.rx));
    turned_sums[2] = add_turn(turned_sums[2], longint'(smp.ry));
    res.tilt_z   = cordic_angle(longint'(smp.ax), longint'(smp.ay));
    res.tilt_x   = cordic_angle(longint'(smp.az), longint'(smp.ay));
    res.tilt_y   = cordic_angle(longint'(smp.ax), longint'(smp.az));
    res.turned_z = SW'(turned_sums[0]);
    res.turned_x = SW'(turned_sums[1]);
    res.turned_y = SW'(turned_sums[2]);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic signed [AW-1:0] rand_axis(input int lo, input int hi);
    return AW'(int'($urandom_range(0, hi - lo)) + lo);
  endfunction

  function automatic logic signed [AW-1:0] edge_axis();
    case ($urandom_range(0, 5))
      0:       return -16'sd32768;
      1:       return -16'sd32767;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  function automatic logic signed [AW-1:0] mixed_axis(input sample_mix_t mix);
    int pick;
    pick = $urandom_range(0, 7);
    // every phase keeps a sprinkling of near-zero and extreme values
    if (mix == MIX_TINY || pick == 0) return rand_axis(-300, 300);
    if (mix == MIX_EDGE || pick == 1) return edge_axis();
    return rand_axis(-32768, 32767);
  endfunction

  // sender idle cycles after a beat: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 5);
    return $urandom_range(20, 120);
  endfunction

  // receiver stall after a beat; every fourth run of 40 beats has none
  function automatic int pick_stall();
    int r;
    if ((beats_seen / 40) % 4 == 3) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 6);
    return $urandom_range(20, 150);
  endfunction

  task automatic add_sample(input int ax, input int ay, input int az,
                            input int rx, input int ry, input int rz,
                            input logic hurry);
    feed_entry_t e;
    e.kind  = FEED_SAMPLE;
    e.hurry = hurry;
    e.gain  = '0;
    e.ax    = AW'(ax);
    e.ay    = AW'(ay);
    e.az    = AW'(az);
    e.rx    = AW'(rx);
    e.ry    = AW'(ry);
    e.rz    = AW'(rz);
    sample_feed.push_back(e);
  endtask

  task automatic add_control(input feed_kind_t kind, input int gain);
    feed_entry_t e;
    e      = '0;
    e.kind = kind;
    e.gain = GW'(gain);
    sample_feed.push_back(e);
  endtask

  task automatic add_phase(input int gain, input sample_mix_t mix, input int count,
                           input logic hurry);
    logic signed [AW-1:0] rx;
    logic signed [AW-1:0] ry;
    logic signed [AW-1:0] rz;
    add_control(FEED_GAIN, gain);
    for (int n = 0; n < count; n++) begin
      case (mix)
        MIX_RAMP_UP: begin
          rx = rand_axis(20000, 32767);
          ry = rand_axis(20000, 32767);
          rz = rand_axis(-32768, -20000);
        end
        MIX_RAMP_DOWN: begin
          rx = rand_axis(-32768, -20000);
          ry = rand_axis(-32768, -20000);
          rz = rand_axis(20000, 32767);
        end
        default: begin
          rx = mixed_axis(mix);
          ry = mixed_axis(mix);
          rz = mixed_axis(mix);
        end
      endcase
      add_sample(mixed_axis(mix), mixed_axis(mix), mixed_axis(mix), rx, ry, rz, hurry);
      // sender now and then holds off until the block has fully drained
      if (n == count / 2 || $urandom_range(0, 99) == 0) add_control(FEED_DRAIN, 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers samples and gain writes from sample_feed
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid  <= 1'b0;
      cfg_wr_en <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (s_tvalid && s_tready) pending_results.push_back(predict_sample(in_flight));

      if (s_tvalid && !s_tready) begin
        // beat still on offer; hold tdata and tvalid
        cfg_wr_en <= 1'b0;
      end else if (send_gap > 0) begin
        send_gap  <= send_gap - 1;
        s_tvalid  <= 1'b0;
        cfg_wr_en <= 1'b0;
      end else if (sample_feed.size() == 0) begin
        s_tvalid  <= 1'b0;
        cfg_wr_en <= 1'b0;
      end else if (sample_feed[0].kind == FEED_SAMPLE) begin
        in_flight = sample_feed.pop_front();
        s_tdata   <= {in_flight.rz, in_flight.ry, in_flight.rx,
                      in_flight.az, in_flight.ay, in_flight.ax};
        s_tvalid  <= 1'b1;
        cfg_wr_en <= 1'b0;
        send_gap  <= in_flight.hurry ? 0 : pick_gap();
      end else begin
        // gain writes and drain points wait until every result has come back
        s_tvalid <= 1'b0;
        if (pending_results.size() == 0) begin
          head = sample_feed.pop_front();
          if (head.kind == FEED_GAIN) begin
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= head.gain;
            gain_model  = longint'(head.gain);
          end else begin
            cfg_wr_en <= 1'b0;
          end
        end else begin
          cfg_wr_en <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random backpressure, field-by-field check of each result beat
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      fault_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      take_stall <= 0;
    end else if (m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_results.size() == 0) begin
        fault_count++;
        $display("%0t: result beat with none expected, expected nothing, actual %h",
                 $time, m_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("tilt_about_z",   longint'(want.tilt_z),   longint'(got.tilt_z));
        check_field("tilt_about_x",   longint'(want.tilt_x),   longint'(got.tilt_x));
        check_field("tilt_about_y",   longint'(want.tilt_y),   longint'(got.tilt_y));
        check_field("turned_about_z", longint'(want.turned_z), longint'(got.turned_z));
        check_field("turned_about_x", longint'(want.turned_x), longint'(got.turned_x));
        check_field("turned_about_y", longint'(want.turned_y), longint'(got.turned_y));
      end
      beats_seen++;
      stall_pick = pick_stall();
      if (stall_pick > 0) begin
        m_tready   <= 1'b0;
        take_stall <= stall_pick - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end else if (take_stall > 0) begin
      take_stall <= take_stall - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    turned_sums[0] = 0;
    turned_sums[1] = 0;
    turned_sums[2] = 0;
    gain_model     = 10;    // rate_gain after reset
    beats_seen     = 0;
    fault_count    = 0;

    // directed: origin, axes, every quadrant, the pi clamp, full-scale rates
    add_sample(0, 0, 0, 0, 0, 0, 1'b1);                    // both operands zero
    add_sample(0, 100, 0, 1, -1, 0, 1'b1);
    add_sample(100, 0, 0, -1, 1, 0, 1'b1);
    add_sample(0, -100, 0, 0, 0, 0, 1'b1);                 // exactly pi, clamped
    add_sample(0, -1, 0, 21845, -21846, 1, 1'b1);
    add_sample(0, 0, -5, -21846, 21845, -1, 1'b1);
    add_sample(-100, -100, -100, 300, 300, 300, 1'b1);
    add_sample(100, -100, 100, -300, -300, -300, 1'b1);
    add_sample(-100, 100, -100, 7, 8, 9, 1'b1);
    add_sample(32767, 32767, 32767, 32767, 32767, 32767, 1'b1);
    add_sample(-32768, -32768, -32768, -32768, -32768, -32768, 1'b1);
    add_sample(-32768, 32767, -32768, 32767, -32768, 32767, 1'b1);
    add_sample(32767, -32768, 0, -32768, 32767, -32768, 1'b1);
    add_sample(1, -1, -1, 1, 1, 1, 1'b1);
    add_sample(-1, 0, 1, -1, -1, -1, 1'b1);
    add_sample(0, -32768, -1, 0, 0, 0, 1'b1);
    add_sample(-1, -32768, 32767, 12345, -12345, 0, 1'b1);
    add_sample(32767, 1, -32768, -4660, 4660, 255, 1'b1);

    // random phases, each after a gain write; the ramps drive the sums into
    // both saturation limits, gain zero then checks they stay frozen
    add_phase(1, MIX_FULL, 60, 1'b0);
    add_phase(4095, MIX_RAMP_UP, 60, 1'b0);
    add_phase(4095, MIX_RAMP_DOWN, 60, 1'b1);
    add_phase(0, MIX_FULL, 60, 1'b0);
    add_phase($urandom_range(1, 4094), MIX_TINY, 60, 1'b0);
    add_phase(2048, MIX_RAMP_UP, 60, 1'b0);
    add_phase(10, MIX_EDGE, 60, 1'b0);
    add_phase($urandom_range(0, 4095), MIX_FULL, 60, 1'b1);
    add_phase($urandom_range(0, 4095), MIX_TINY, 60, 1'b0);
    add_phase($urandom_range(0, 4095), MIX_FULL, 60, 1'b0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // sample on the falling edge so the driver's updates have settled
    while (sample_feed.size() != 0 || s_tvalid || pending_results.size() != 0)
      @(negedge clk);
    // let any stray result beat show up before the verdict
    repeat (80) @(posedge clk);

    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #15000000;
    $display("simulation failed");
    $finish;
  end

endmodule
